[rtl/lbgk_pkg.sv]
// Shared constants, register map and direction tables for the D2Q9 BGK collision block.
package lbgk_pkg;

  localparam int unsigned DATA_WIDTH = 24;
  localparam int unsigned DIRECTIONS = 9;
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned NUM_INPUTS = 12;

  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 23;
  localparam int unsigned RATE_W     = 22;
  localparam int unsigned KINV_W     = 23;
  localparam int unsigned WGT_W      = 21;

  localparam logic [RATE_W-1:0] RATE_RST   = 22'd1048576;
  localparam logic [KINV_W-1:0] KINV_RST   = 23'd3145728;
  localparam logic [WGT_W-1:0]  W_REST_RST = 21'd466034;
  localparam logic [WGT_W-1:0]  W_AXIS_RST = 21'd116508;
  localparam logic [WGT_W-1:0]  W_DIAG_RST = 21'd29127;

  typedef enum logic [CFG_AW-1:0] {
    REG_RELAX_RATE = 3'd0,
    REG_INV_CS_SQ  = 3'd1,
    REG_W_REST     = 3'd2,
    REG_W_AXIS     = 3'd3,
    REG_W_DIAG     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_REST = 2'd0,
    CLS_AXIS = 2'd1,
    CLS_DIAG = 2'd2
  } dir_class_e;

  function automatic int dir_x(input int i);
    case (i)
      1, 5, 8: dir_x = 1;
      3, 6, 7: dir_x = -1;
      default: dir_x = 0;
    endcase
  endfunction

  function automatic int dir_y(input int i);
    case (i)
      2, 5, 6: dir_y = 1;
      4, 7, 8: dir_y = -1;
      default: dir_y = 0;
    endcase
  endfunction

  function automatic dir_class_e dir_class(input int i);
    case (i)
      0:          dir_class = CLS_REST;
      1, 2, 3, 4: dir_class = CLS_AXIS;
      default:    dir_class = CLS_DIAG;
    endcase
  endfunction

endpackage

[rtl/lattice_bgk_collision.sv]
// Top level of the D2Q9 BGK collision pipeline with its register file.
//
//  port group     dir  beat contents
//  s_axis_*       in   one node: density, vel_x, vel_y, nine distributions
//  m_axis_*       out  nine post-collision distributions
//  cfg_*          in   register writes, index 0..4
//
// The pipeline takes one node per cycle while the output beat is not stalled.
// Each of the eight register stages holds about one multiply or one wide add.
// Reset clears the stage valid bits and loads the default register values.
// A stalled output beat freezes the whole pipeline; s_axis_tready drops with it.
module lattice_bgk_collision #(
  parameter int unsigned DATA_WIDTH = lbgk_pkg::DATA_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // density, vel_x, vel_y, f_rest, f_east, f_north, f_west, f_south,
  // f_northeast, f_northwest, f_southwest, f_southeast
  input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // g_rest, g_east, g_north, g_west, g_south, g_northeast, g_northwest,
  // g_southwest, g_southeast
  output logic [((9*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [lbgk_pkg::CFG_AW-1:0]            cfg_addr_i,
  input  logic [lbgk_pkg::CFG_DW-1:0]            cfg_wdata_i
);
  import lbgk_pkg::*;

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned EW     = DW + 2;
  localparam int unsigned WRW    = DW + 2;
  localparam int unsigned USQW   = 2*DW - 19;
  localparam int unsigned HKW    = 2*DW - 16;
  localparam int unsigned OUT_TW = ((9*DATA_WIDTH+7)/8)*8;
  localparam int unsigned STAGES = 8;

  logic [RATE_W-1:0] rate_q;
  logic [KINV_W-1:0] kinv_q;
  logic [WGT_W-1:0]  w_rest_q, w_axis_q, w_diag_q;

  logic [STAGES-1:0] vld_q;
  logic              en;

  logic signed [DW-1:0] rho, ux, uy;
  logic signed [2*DW-1:0]      uxx_p, uyy_p;
  logic signed [2*DW-1:0]      uxx_q, uyy_q;
  logic signed [2*DW:0]        usum;
  logic signed [USQW-1:0]      usq_q;
  logic signed [USQW+23:0]     hk_p;
  logic signed [HKW-1:0]       hk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RATE_RST;
      kinv_q   <= KINV_RST;
      w_rest_q <= W_REST_RST;
      w_axis_q <= W_AXIS_RST;
      w_diag_q <= W_DIAG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_RELAX_RATE: rate_q   <= cfg_wdata_i[RATE_W-1:0];
        REG_INV_CS_SQ:  kinv_q   <= cfg_wdata_i[KINV_W-1:0];
        REG_W_REST:     w_rest_q <= cfg_wdata_i[WGT_W-1:0];
        REG_W_AXIS:     w_axis_q <= cfg_wdata_i[WGT_W-1:0];
        REG_W_DIAG:     w_diag_q <= cfg_wdata_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !vld_q[STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], s_axis_tvalid};
    end
  end

  assign rho   = s_axis_tdata[0 +: DW];
  assign ux    = s_axis_tdata[DW +: DW];
  assign uy    = s_axis_tdata[2*DW +: DW];
  assign uxx_p = ux * ux;
  assign uyy_p = uy * uy;
  assign usum  = (2*DW+1)'(uxx_q) + (2*DW+1)'(uyy_q);
  assign hk_p  = usq_q * $signed({1'b0, kinv_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      uxx_q <= uxx_p;
      uyy_q <= uyy_p;
      usq_q <= usum[2*DW:20];
      hk_q  <= hk_p[USQW+23:21];
    end
  end

  for (genvar i = 0; i < DIRECTIONS; i++) begin : g_dir
    logic signed [EW-1:0]     ex, ey;
    logic        [WGT_W-1:0]  w;
    logic signed [DW+21:0]    wr_p;
    logic signed [EW-1:0]     eu_q;
    logic signed [WRW-1:0]    wr_q;
    logic signed [DW-1:0]     f_q;
    logic signed [DW-1:0]     g;

    always_comb begin
      case (dir_x(i))
        1:       ex = EW'(ux);
        -1:      ex = -EW'(ux);
        default: ex = '0;
      endcase
      case (dir_y(i))
        1:       ey = EW'(uy);
        -1:      ey = -EW'(uy);
        default: ey = '0;
      endcase
      case (dir_class(i))
        CLS_REST: w = w_rest_q;
        CLS_AXIS: w = w_axis_q;
        default:  w = w_diag_q;
      endcase
    end

    assign wr_p = $signed({1'b0, w}) * rho;

    always_ff @(posedge clk_i) begin
      if (en) begin
        eu_q <= ex + ey;
        wr_q <= wr_p[DW+21:20];
        f_q  <= s_axis_tdata[(3+i)*DW +: DW];
      end
    end

    lbgk_lane #(
      .DW (DW)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .eu_i   (eu_q),
      .wr_i   (wr_q),
      .f_i    (f_q),
      .kinv_i (kinv_q),
      .rate_i (rate_q),
      .hk_i   (hk_q),
      .g_o    (g)
    );

    assign m_axis_tdata[i*DW +: DW] = g;
  end

  if (OUT_TW > 9*DW) begin : g_pad
    assign m_axis_tdata[OUT_TW-1:9*DW] = '0;
  end

endmodule

[rtl/lbgk_lane.sv]
// One direction of the collision pipeline: equilibrium, relaxation and saturation.
module lbgk_lane #(
  parameter int unsigned DW = lbgk_pkg::DATA_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [DW+1:0]                   eu_i,
  input  logic signed [DW+1:0]                   wr_i,
  input  logic signed [DW-1:0]                   f_i,
  input  logic        [lbgk_pkg::KINV_W-1:0]     kinv_i,
  input  logic        [lbgk_pkg::RATE_W-1:0]     rate_i,
  input  logic signed [2*DW-17:0]                hk_i,
  output logic signed [DW-1:0]                   g_o
);
  import lbgk_pkg::*;

  localparam int unsigned EW   = DW + 2;
  localparam int unsigned CW   = EW + 4;
  localparam int unsigned SQW  = 2*CW - 21;
  localparam int unsigned PW   = SQW + 2;
  localparam int unsigned PHW  = PW - FRAC_BITS;
  localparam int unsigned WRW  = DW + 2;
  localparam int unsigned FEQW = WRW + PHW;
  localparam int unsigned FLPW = WRW + FRAC_BITS + 1;
  localparam int unsigned FLW  = FLPW - FRAC_BITS;
  localparam int unsigned DFW  = FEQW + 1;
  localparam int unsigned DHW  = DFW - FRAC_BITS;
  localparam int unsigned RW   = DHW + RATE_W + 1;
  localparam int unsigned RLPW = FRAC_BITS + RATE_W + 2;
  localparam int unsigned RLW  = RLPW - FRAC_BITS;
  localparam int unsigned GW   = RW + 1;

  logic signed [EW+23:0]    cu_p;
  logic signed [2*CW-1:0]   sq_p;
  logic signed [FEQW-1:0]   fhi_p;
  logic signed [FLPW-1:0]   flo_p;
  logic signed [DFW-1:0]    d_w;
  logic signed [RW-1:0]     rhi_p;
  logic signed [RLPW-1:0]   rlo_p;
  logic signed [GW-1:0]     g_w;

  logic signed [CW-1:0]   cu_q,  cu3_q;
  logic signed [SQW-1:0]  sq_q;
  logic signed [PW-1:0]   p_q;
  logic signed [FEQW-1:0] fhi_q;
  logic signed [FLW-1:0]  flo_q;
  logic signed [DFW-1:0]  d_q;
  logic signed [RW-1:0]   rhi_q;
  logic signed [RLW-1:0]  rlo_q;
  logic signed [WRW-1:0]  wr2_q, wr3_q, wr4_q;
  logic signed [DW-1:0]   f2_q, f3_q, f4_q, f5_q, f6_q, f7_q, g_q;
  logic signed [DW-1:0]   g_d;

  assign cu_p  = eu_i * $signed({1'b0, kinv_i});
  assign sq_p  = cu_q * cu_q;
  assign fhi_p = wr4_q * $signed(p_q[PW-1:FRAC_BITS]);
  assign flo_p = wr4_q * $signed({1'b0, p_q[FRAC_BITS-1:0]});
  assign d_w   = DFW'(fhi_q) + DFW'(flo_q) - DFW'(f5_q);
  assign rhi_p = $signed(d_q[DFW-1:FRAC_BITS]) * $signed({1'b0, rate_i});
  assign rlo_p = $signed({1'b0, d_q[FRAC_BITS-1:0]}) * $signed({1'b0, rate_i});
  assign g_w   = GW'(rhi_q) + GW'(rlo_q) + GW'(f7_q);

  always_comb begin
    if (g_w[GW-1:DW-1] == '0 || g_w[GW-1:DW-1] == '1) begin
      g_d = g_w[DW-1:0];
    end else if (g_w[GW-1]) begin
      g_d = {1'b1, {(DW-1){1'b0}}};
    end else begin
      g_d = {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cu_q  <= cu_p[EW+23:20];
      wr2_q <= wr_i;
      f2_q  <= f_i;
      sq_q  <= sq_p[2*CW-1:21];
      cu3_q <= cu_q;
      wr3_q <= wr2_q;
      f3_q  <= f2_q;
      p_q   <= PW'(33'sd1 <<< FRAC_BITS) + PW'(cu3_q) + PW'(sq_q) - PW'(hk_i);
      wr4_q <= wr3_q;
      f4_q  <= f3_q;
      fhi_q <= fhi_p;
      flo_q <= flo_p[FLPW-1:FRAC_BITS];
      f5_q  <= f4_q;
      d_q   <= d_w;
      f6_q  <= f5_q;
      rhi_q <= rhi_p;
      rlo_q <= rlo_p[RLPW-1:FRAC_BITS];
      f7_q  <= f6_q;
      g_q   <= g_d;
    end
  end

  assign g_o = g_q;

endmodule
